[sv/wsd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package wsd_pkg;

	// Parser phase
	typedef enum logic [2:0] {
		PH_FIRST   = 3'd0,
		PH_SECOND  = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_KEY     = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	// Result kinds
	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	// Header byte fields
	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	typedef struct packed {
		logic        kind;
		logic        fin_flag;
		logic [3:0]  opcode;
		logic        is_masked;
		logic [63:0] pay_len;
		logic [31:0] mask_key;
		logic [7:0]  payload_byte;
		logic        frame_end;
	} res_t;

endpackage
`default_nettype wire

[sv/wsd_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface wsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

[sv/wsd_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface wsd_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic        fin_flag;
	logic [3:0]  opcode;
	logic        is_masked;
	logic [63:0] pay_len;
	logic [31:0] mask_key;
	logic [7:0]  payload_byte;
	logic        frame_end;

	modport source (
		output valid, output kind, output fin_flag, output opcode, output is_masked,
		output pay_len, output mask_key, output payload_byte, output frame_end,
		input ready
	);
	modport sink (
		input valid, input kind, input fin_flag, input opcode, input is_masked,
		input pay_len, input mask_key, input payload_byte, input frame_end,
		output ready
	);
endinterface
`default_nettype wire

[sv/wsd_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
module wsd_parser (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    in_byte,
	output logic               res_valid,
	output wsd_pkg::res_t      res
);

	wsd_pkg::phase_t phase_q, phase_d;
	logic [3:0]  cnt_q, cnt_d;
	logic        fin_q, fin_d;
	logic [3:0]  opc_q, opc_d;
	logic        msk_q, msk_d;
	logic [63:0] len_q, len_d;
	logic [31:0] key_q, key_d;
	logic [63:0] left_q, left_d;
	logic [1:0]  kidx_q, kidx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wsd_pkg::PH_FIRST;
			cnt_q   <= '0;
			fin_q   <= 1'b0;
			opc_q   <= '0;
			msk_q   <= 1'b0;
			len_q   <= '0;
			key_q   <= '0;
			left_q  <= '0;
			kidx_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			fin_q   <= fin_d;
			opc_q   <= opc_d;
			msk_q   <= msk_d;
			len_q   <= len_d;
			key_q   <= key_d;
			left_q  <= left_d;
			kidx_q  <= kidx_d;
		end
	end

	always_comb begin
		logic       after_len;
		logic       hdr_done;
		logic [7:0] kbyte;
		logic [7:0] pbyte;
		logic       pend;

		after_len = 1'b0;
		hdr_done  = 1'b0;
		kbyte     = '0;
		pbyte     = '0;
		pend      = 1'b0;
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		fin_d     = fin_q;
		opc_d     = opc_q;
		msk_d     = msk_q;
		len_d     = len_q;
		key_d     = key_q;
		left_d    = left_q;
		kidx_d    = kidx_q;
		res_valid = 1'b0;
		res       = '0;

		case (phase_q)
			wsd_pkg::PH_FIRST: begin
				fin_d   = in_byte[7];
				opc_d   = in_byte[3:0];
				msk_d   = 1'b0;
				len_d   = '0;
				key_d   = '0;
				left_d  = '0;
				kidx_d  = '0;
				cnt_d   = '0;
				phase_d = wsd_pkg::PH_SECOND;
			end
			wsd_pkg::PH_SECOND: begin
				msk_d = in_byte[7];
				len_d = '0;
				if (in_byte[6:0] == wsd_pkg::LEN7_EXT16) begin
					phase_d = wsd_pkg::PH_EXTLEN;
					cnt_d   = wsd_pkg::EXT16_BYTES;
				end else if (in_byte[6:0] == wsd_pkg::LEN7_EXT64) begin
					phase_d = wsd_pkg::PH_EXTLEN;
					cnt_d   = wsd_pkg::EXT64_BYTES;
				end else begin
					len_d     = {57'd0, in_byte[6:0]};
					after_len = 1'b1;
				end
			end
			wsd_pkg::PH_EXTLEN: begin
				len_d = {len_q[55:0], in_byte};
				cnt_d = cnt_q - 4'd1;
				if (cnt_d == 4'd0) begin
					after_len = 1'b1;
				end
			end
			wsd_pkg::PH_KEY: begin
				key_d = {key_q[23:0], in_byte};
				cnt_d = cnt_q - 4'd1;
				if (cnt_d == 4'd0) begin
					hdr_done = 1'b1;
				end
			end
			wsd_pkg::PH_PAYLOAD: begin
				// key byte 0 is the first one received, i.e. the top byte
				case (kidx_q)
					2'd0: kbyte = key_q[31:24];
					2'd1: kbyte = key_q[23:16];
					2'd2: kbyte = key_q[15:8];
					default: kbyte = key_q[7:0];
				endcase
				pbyte  = msk_q ? (in_byte ^ kbyte) : in_byte;
				kidx_d = kidx_q + 2'd1;
				left_d = (left_q != 64'd0) ? (left_q - 64'd1) : 64'd0;
				pend   = (left_q[63:1] == 63'd0);
				if (pend) begin
					phase_d = wsd_pkg::PH_FIRST;
				end
				res_valid = 1'b1;
				res.kind  = wsd_pkg::KIND_PAYLOAD;
			end
			default: begin
				phase_d = wsd_pkg::PH_FIRST;
			end
		endcase

		if (after_len) begin
			if (msk_d) begin
				phase_d = wsd_pkg::PH_KEY;
				cnt_d   = wsd_pkg::KEY_BYTES;
			end else begin
				hdr_done = 1'b1;
			end
		end

		if (hdr_done) begin
			left_d    = len_d;
			kidx_d    = '0;
			pend      = (len_d == 64'd0);
			phase_d   = pend ? wsd_pkg::PH_FIRST : wsd_pkg::PH_PAYLOAD;
			res_valid = 1'b1;
			res.kind  = wsd_pkg::KIND_HEADER;
		end

		res.fin_flag     = fin_d;
		res.opcode       = opc_d;
		res.is_masked    = msk_d;
		res.pay_len      = len_d;
		res.mask_key     = key_d;
		res.payload_byte = pbyte;
		res.frame_end    = pend;
	end

	// a payload phase always has at least one byte still to come
	a_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == wsd_pkg::PH_PAYLOAD |-> left_q != 64'd0)
		else $error("payload phase with no bytes left");

	a_first_to_second: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == wsd_pkg::PH_FIRST |=> phase_q == wsd_pkg::PH_SECOND)
		else $error("first header byte did not advance to second");

	a_payload_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == wsd_pkg::KIND_PAYLOAD |-> phase_q == wsd_pkg::PH_PAYLOAD)
		else $error("payload result outside payload phase");

endmodule
`default_nettype wire

[sv/wsd_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none
module wsd_out_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire wsd_pkg::res_t din,
	output logic               space,
	wsd_out_if.source          result
);

	logic          valid_q;
	wsd_pkg::res_t data_q;

	assign space = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && space) begin
			data_q <= din;
		end
	end

	assign result.valid        = valid_q;
	assign result.kind         = data_q.kind;
	assign result.fin_flag     = data_q.fin_flag;
	assign result.opcode       = data_q.opcode;
	assign result.is_masked    = data_q.is_masked;
	assign result.pay_len      = data_q.pay_len;
	assign result.mask_key     = data_q.mask_key;
	assign result.payload_byte = data_q.payload_byte;
	assign result.frame_end    = data_q.frame_end;

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load && space |=> valid_q)
		else $error("loaded result not presented");

endmodule
`default_nettype wire

[sv/websocket_frame_deframer.sv]
`timescale 1ns / 1ps
`default_nettype none
// WebSocket (RFC 6455) receive-side deframer.
// stream : one raw frame byte per request (in_byte), valid/ready.
// result : one request per header completion (kind 0) and per payload byte
//          (kind 1, unmasked), with the frame's FIN, opcode, mask flag,
//          decoded length and key; frame_end marks the frame's last request.
// Header bytes other than the last give no result request.
// Path: an accepted byte passes through the input register, then the parser
// into the result register.
// Throughput: one byte per cycle, sustained while the result side does not
// stall; the parser state updates once per byte, so that loop sets the rate.
// Stall: when result.ready is low and the result register is full, a byte that
// yields a result waits in the input register and stream.ready drops; header
// bytes that yield nothing keep flowing.
// Reset: arst_n clears both registers' valid flags and returns the parser to
// waiting for the first header byte of a frame; lengths and key read as zero.
module websocket_frame_deframer (
	input  wire logic clk,
	input  wire logic arst_n,
	wsd_in_if.sink    stream,
	wsd_out_if.source result
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          advance;
	logic          space;
	logic          res_valid;
	wsd_pkg::res_t res;

	// a byte moves on if it yields nothing or the result register has room
	assign advance      = valid_s1 && (!res_valid || space);
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.in_byte;
		end
	end

	wsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.in_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	wsd_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && res_valid),
		.din    (res),
		.space  (space),
		.result (result)
	);

	// a held byte stays put until the parser takes it
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("input register lost a byte");

endmodule
`default_nettype wire

[dv/websocket_frame_deframer_tb.sv]
`timescale 1ns / 1ps
module websocket_frame_deframer_tb;

	// Frame opcodes used by the directed frames
	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_RSVD_F = 4'hF;

	// Run shape, counted in stream requests unless noted: queued ones for ITEMS and DRAIN_AT, accepted ones for the rest
	localparam int ITEMS          = 1600;
	localparam int DRAIN_AT       = 800;   // sender waits for all results here
	localparam int NO_IDLE_FROM   = 300;   // neither side idles in this window
	localparam int NO_IDLE_TO     = 700;
	localparam int HOLDOFF_AT     = 1100;  // receiver starts its long hold-off
	localparam int HOLDOFF_CYCLES = 300;   // cycles
	localparam int STALL_LIMIT    = 5000;  // cycles with no request moving
	localparam int TAIL_CYCLES    = 8;     // pipeline is two deep, plenty of slack
	localparam int DRAIN_MARK     = -1;    // queue entry: pause until drained

	// How the payload length is encoded in the header
	typedef enum int {ENC_SHORT, ENC_EXT16, ENC_EXT64} len_enc_t;

	logic clk;
	logic arst_n;

	wsd_in_if  stream_if ();
	wsd_out_if result_if ();

	websocket_frame_deframer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.result (result_if)
	);

	// ------------------------------------------------------------------
	// Deframer prediction: own copy of the parser state
	// ------------------------------------------------------------------
	wsd_pkg::phase_t parse_phase;
	logic [3:0]  ext_left;      // extended-length or key bytes still to come
	logic        hdr_fin;
	logic [3:0]  hdr_opcode;
	logic        hdr_masked;
	logic [63:0] frame_len;
	logic [31:0] frame_key;
	logic [63:0] remaining;     // payload bytes still owed by the frame
	logic [1:0]  key_pos;       // which key byte unmasks the next payload byte

	wsd_pkg::res_t expected_results[$];

	// Snapshot of the current frame header plus the per-request fields
	function void queue_result(input logic kind, input logic [7:0] pbyte, input logic last);
		wsd_pkg::res_t r;
		r.kind         = kind;
		r.fin_flag     = hdr_fin;
		r.opcode       = hdr_opcode;
		r.is_masked    = hdr_masked;
		r.pay_len      = frame_len;
		r.mask_key     = frame_key;
		r.payload_byte = pbyte;
		r.frame_end    = last;
		expected_results.insert(expected_results.size(), r);
	endfunction

	// Header finished: a zero-length frame ends right here on its header result
	function void header_complete();
		remaining = frame_len;
		key_pos   = 2'd0;
		if (frame_len == 64'd0) begin
			parse_phase = wsd_pkg::PH_FIRST;
			queue_result(wsd_pkg::KIND_HEADER, 8'h00, 1'b1);
		end else begin
			parse_phase = wsd_pkg::PH_PAYLOAD;
			queue_result(wsd_pkg::KIND_HEADER, 8'h00, 1'b0);
		end
	endfunction

	function void length_known();
		if (hdr_masked) begin
			parse_phase = wsd_pkg::PH_KEY;
			ext_left    = wsd_pkg::KEY_BYTES;
		end else begin
			header_complete();
		end
	endfunction

	function void deframe_byte(input logic [7:0] b);
		logic [7:0] pb;
		case (parse_phase)
			wsd_pkg::PH_FIRST: begin
				// RSV bits 6..4 are dropped on the floor
				hdr_fin     = b[7];
				hdr_opcode  = b[3:0];
				hdr_masked  = 1'b0;
				frame_len   = 64'd0;
				frame_key   = 32'd0;
				remaining   = 64'd0;
				key_pos     = 2'd0;
				ext_left    = 4'd0;
				parse_phase = wsd_pkg::PH_SECOND;
			end
			wsd_pkg::PH_SECOND: begin
				hdr_masked = b[7];
				frame_len  = 64'd0;
				if (b[6:0] == wsd_pkg::LEN7_EXT16) begin
					parse_phase = wsd_pkg::PH_EXTLEN;
					ext_left    = wsd_pkg::EXT16_BYTES;
				end else if (b[6:0] == wsd_pkg::LEN7_EXT64) begin
					parse_phase = wsd_pkg::PH_EXTLEN;
					ext_left    = wsd_pkg::EXT64_BYTES;
				end else begin
					frame_len = {57'd0, b[6:0]};
					length_known();
				end
			end
			wsd_pkg::PH_EXTLEN: begin
				// big-endian, taken as is: top bit and non-minimal forms allowed
				frame_len = {frame_len[55:0], b};
				ext_left  = ext_left - 4'd1;
				if (ext_left == 4'd0)
					length_known();
			end
			wsd_pkg::PH_KEY: begin
				frame_key = {frame_key[23:0], b};
				ext_left  = ext_left - 4'd1;
				if (ext_left == 4'd0)
					header_complete();
			end
			wsd_pkg::PH_PAYLOAD: begin
				// first key byte received unmasks payload byte 0
				pb = hdr_masked ? (b ^ frame_key[8 * (3 - key_pos) +: 8]) : b;
				key_pos = key_pos + 2'd1;
				if (remaining != 64'd0)
					remaining = remaining - 64'd1;
				if (remaining == 64'd0)
					parse_phase = wsd_pkg::PH_FIRST;
				queue_result(wsd_pkg::KIND_PAYLOAD, pb, remaining == 64'd0);
			end
			default: begin
				parse_phase = wsd_pkg::PH_FIRST;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus: raw stream bytes, DRAIN_MARK entries stall the sender
	// ------------------------------------------------------------------
	int byte_queue[$];

	function void add_byte(input int v);
		byte_queue.insert(byte_queue.size(), v);
	endfunction

	task automatic add_frame(input logic fin, input logic [3:0] op, input logic [2:0] rsv,
			input logic masked, input len_enc_t enc, input logic [63:0] len,
			input logic [31:0] key, input int body);
		logic [6:0] len7;
		len7 = (enc == ENC_EXT16) ? wsd_pkg::LEN7_EXT16 :
		       (enc == ENC_EXT64) ? wsd_pkg::LEN7_EXT64 : len[6:0];
		add_byte(int'({fin, rsv, op}));
		add_byte(int'({masked, len7}));
		if (enc == ENC_EXT16) begin
			add_byte(int'(len[15:8]));
			add_byte(int'(len[7:0]));
		end else if (enc == ENC_EXT64) begin
			for (int i = 7; i >= 0; i--)
				add_byte(int'(len[8 * i +: 8]));
		end
		if (masked) begin
			for (int i = 3; i >= 0; i--)
				add_byte(int'(key[8 * i +: 8]));
		end
		for (int i = 0; i < body; i++)
			add_byte(int'($urandom_range(0, 255)));
	endtask

	// ------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// Handshake bookkeeping at the rising edge
	// ------------------------------------------------------------------
	logic byte_taken;      // stream request accepted at the last rising edge
	int   bytes_taken;
	int   errors;
	int   stall_cycles;
	int   holdoff_left;
	logic holdoff_done;

	wire in_fire  = stream_if.valid && stream_if.ready;
	wire out_fire = result_if.valid && result_if.ready;

	initial begin
		stream_if.valid   = 1'b0;
		stream_if.in_byte = 8'h00;
		result_if.ready   = 1'b0;
		byte_taken        = 1'b0;
		bytes_taken       = 0;
		errors            = 0;
		stall_cycles      = 0;
		holdoff_left      = 0;
		holdoff_done      = 1'b0;
		parse_phase       = wsd_pkg::PH_FIRST;
		ext_left          = 4'd0;
		hdr_fin           = 1'b0;
		hdr_opcode        = 4'd0;
		hdr_masked        = 1'b0;
		frame_len         = 64'd0;
		frame_key         = 32'd0;
		remaining         = 64'd0;
		key_pos           = 2'd0;
	end

	// Predict on every accepted stream request, check every accepted result request
	always @(posedge clk) begin
		wsd_pkg::res_t got;
		wsd_pkg::res_t want;
		if (arst_n) begin
			byte_taken <= in_fire;
			if (in_fire) begin
				deframe_byte(stream_if.in_byte);
				bytes_taken <= bytes_taken + 1;
			end
			if (out_fire) begin
				got.kind         = result_if.kind;
				got.fin_flag     = result_if.fin_flag;
				got.opcode       = result_if.opcode;
				got.is_masked    = result_if.is_masked;
				got.pay_len      = result_if.pay_len;
				got.mask_key     = result_if.mask_key;
				got.payload_byte = result_if.payload_byte;
				got.frame_end    = result_if.frame_end;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected k=%0d f=%0d op=%h m=%0d len=%h key=%h",
						$time, got.kind, got.fin_flag, got.opcode, got.is_masked,
						got.pay_len, got.mask_key);
					$display("  b=%h e=%0d, expected none", got.payload_byte,
						got.frame_end);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						$display("%0t: result mismatch", $time);
						$display("  exp k=%0d f=%0d op=%h m=%0d len=%h key=%h b=%h e=%0d",
							want.kind, want.fin_flag, want.opcode, want.is_masked,
							want.pay_len, want.mask_key, want.payload_byte,
							want.frame_end);
						$display("  act k=%0d f=%0d op=%h m=%0d len=%h key=%h b=%h e=%0d",
							got.kind, got.fin_flag, got.opcode, got.is_masked,
							got.pay_len, got.mask_key, got.payload_byte,
							got.frame_end);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog: too long without any request moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_fire || out_fire) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("websocket_frame_deframer_tb failed");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Driver and receiver, both at the falling edge
	// ------------------------------------------------------------------
	wire quiet_window = (bytes_taken >= NO_IDLE_FROM) && (bytes_taken < NO_IDLE_TO);

	// Sender: no gaps in the quiet window, nor while the receiver holds off so
	// the block backs up and drops stream.ready
	always @(negedge clk) begin
		logic gap;
		if (!arst_n) begin
			stream_if.valid <= 1'b0;
		end else if (!stream_if.valid || byte_taken) begin
			if (byte_queue.size() != 0 && byte_queue[0] == DRAIN_MARK &&
					expected_results.size() == 0)
				void'(byte_queue.pop_front());
			gap = !quiet_window && holdoff_left == 0 && ($urandom_range(0, 99) < 25);
			if (byte_queue.size() != 0 && byte_queue[0] != DRAIN_MARK && !gap) begin
				stream_if.valid   <= 1'b1;
				stream_if.in_byte <= 8'(byte_queue.pop_front());
			end else begin
				stream_if.valid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure plus one long hold-off counted here
	always @(negedge clk) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else if (holdoff_left != 0) begin
			result_if.ready <= 1'b0;
			holdoff_left    <= holdoff_left - 1;
		end else if (!holdoff_done && bytes_taken >= HOLDOFF_AT) begin
			result_if.ready <= 1'b0;
			holdoff_left    <= HOLDOFF_CYCLES;
			holdoff_done    <= 1'b1;
		end else begin
			result_if.ready <= quiet_window || ($urandom_range(0, 99) >= 25);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int          pick;
		logic        masked;
		logic [63:0] len;
		len_enc_t    enc;
		logic        drain_placed;

		// Directed: zero-length frame
		add_frame(1'b1, OP_TEXT, 3'b000, 1'b0, ENC_SHORT, 64'd0, 32'd0, 0);
		// RSV all set and ignored, masked with an all-ones key
		add_frame(1'b0, OP_CONT, 3'b111, 1'b1, ENC_SHORT, 64'd3, 32'hFFFF_FFFF, 3);
		// non-minimal 16-bit length of zero
		add_frame(1'b1, OP_CLOSE, 3'b000, 1'b0, ENC_EXT16, 64'd0, 32'd0, 0);
		// 64-bit length, unmasked payload passes straight through
		add_frame(1'b0, OP_RSVD_F, 3'b101, 1'b0, ENC_EXT64, 64'd1, 32'd0, 1);
		add_frame(1'b1, OP_BINARY, 3'b010, 1'b1, ENC_SHORT, 64'd5, 32'h0000_0000, 5);
		add_byte(DRAIN_MARK);

		// Random well-formed frames: mostly short, some long or oddly encoded
		drain_placed = 1'b0;
		while (byte_queue.size() < ITEMS) begin
			if (!drain_placed && byte_queue.size() >= DRAIN_AT) begin
				add_byte(DRAIN_MARK);
				drain_placed = 1'b1;
			end
			pick   = $urandom_range(0, 99);
			masked = ($urandom_range(0, 99) < 70);
			enc    = ENC_SHORT;
			if (pick < 65) begin
				len = 64'($urandom_range(0, 12));
			end else if (pick < 73) begin
				len = 64'($urandom_range(13, 125));
			end else if (pick < 83) begin
				enc = ENC_EXT16;
				len = 64'($urandom_range(0, 160));
			end else if (pick < 93) begin
				enc = ENC_EXT64;
				len = 64'($urandom_range(0, 24));
			end else begin
				enc = len_enc_t'($urandom_range(0, 2));
				len = 64'd0;
			end
			add_frame(1'($urandom), 4'($urandom), 3'($urandom), masked, enc, len,
				$urandom, int'(len));
		end

		// Last frame claims the largest length, top bit set; only a few bytes follow
		add_frame(1'b1, OP_BINARY, 3'b000, 1'b1, ENC_EXT64, 64'hFFFF_FFFF_FFFF_FFFF,
			$urandom, 6);

		@(posedge arst_n);
		while (byte_queue.size() != 0 || stream_if.valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("websocket_frame_deframer_tb passed");
		else
			$display("websocket_frame_deframer_tb failed");
		$finish;
	end

endmodule
